@@ rtl/hec_pkg.sv @@
// Shared types and constants for the half-edge connectivity builder.
// No dependencies.
`default_nettype none
package hec_pkg;
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FACE_FULL = 2'd1,
    ST_EDGE_FULL = 2'd2
  } status_t;

  localparam int unsigned HASH_U = 32'd40503;
  localparam int unsigned HASH_V = 32'd2654435761;

  // one queued half-edge job from the front to the back
  typedef struct packed {
    logic [9:0]  cur;
    logic [9:0]  nxt;
    logic [11:0] he;
    logic [9:0]  face;
    logic [1:0]  corner;
    logic        first;
    logic        overflow;
  } job_t;
endpackage
`default_nettype wire

@@ rtl/half_edge_connectivity_builder.sv @@
// Top level of the half-edge connectivity builder.
// Depends on hec_pkg, hec_front, hec_queue, hec_back.
//
//   channel   handshake          words
//   in_       start / busy       vertex_a, vertex_b, vertex_c
//   out_      out_strobe         one word per half-edge, three per triangle, one if faces are full
//
// Busy covers the front only; it stays high longer while the two-word job queue is full.
// The back takes one half-edge job at a time: a lookup of the reversed key and, on a
// miss, an insert of the forward key, each walking up to MAX_PROBES slots.
// After reset busy holds high while the vertex bitmap clears;
// the edge table clears as well, and jobs wait in the queue until its clear ends.
// Results appear as one-cycle strobes; the receiver cannot stall them.
`default_nettype none
module half_edge_connectivity_builder #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_FACES    = 1024,
  parameter int TABLE_DEPTH  = 4096,
  parameter int MAX_PROBES   = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [9:0]    in_vertex_a,
  input  wire logic [9:0]    in_vertex_b,
  input  wire logic [9:0]    in_vertex_c,
  output logic               out_strobe,
  output logic [11:0]        out_he_index,
  output logic [9:0]         out_origin_vertex,
  output logic [9:0]         out_face_index,
  output logic [11:0]        out_next_halfedge,
  output logic [11:0]        out_prev_halfedge,
  output logic signed [12:0] out_twin_halfedge,
  output logic [11:0]        out_edge_index,
  output logic               out_edge_created,
  output logic               out_vertex_first,
  output logic [1:0]         out_status,
  output logic               out_last_of_face
);
  hec_pkg::job_t f_job;
  hec_pkg::job_t b_job;
  logic          f_valid;
  logic          f_ready;
  logic          b_valid;
  logic          b_ready;

  hec_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_FACES(MAX_FACES)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b), .in_vertex_c(in_vertex_c),
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  hec_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_job(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_job(b_job), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  hec_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_PROBES(MAX_PROBES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job(b_job), .job_valid(b_valid), .job_ready(b_ready),
    .out_strobe(out_strobe),
    .out_he_index(out_he_index),
    .out_origin_vertex(out_origin_vertex),
    .out_face_index(out_face_index),
    .out_next_halfedge(out_next_halfedge),
    .out_prev_halfedge(out_prev_halfedge),
    .out_twin_halfedge(out_twin_halfedge),
    .out_edge_index(out_edge_index),
    .out_edge_created(out_edge_created),
    .out_vertex_first(out_vertex_first),
    .out_status(out_status),
    .out_last_of_face(out_last_of_face)
  );
endmodule
`default_nettype wire

@@ rtl/hec_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module hec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/hec_front.sv @@
// Front end: accepts triangles, numbers faces, marks first vertex use, queues jobs.
// Depends on hec_pkg and hec_ram (vertex bitmap with clearing sweep).
`default_nettype none
module hec_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_FACES    = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [9:0]    in_vertex_a,
  input  wire logic [9:0]    in_vertex_b,
  input  wire logic [9:0]    in_vertex_c,
  output hec_pkg::job_t      job,
  output logic               job_valid,
  input  wire logic          job_ready
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int FW = $clog2(MAX_FACES + 1) + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_WAIT, S_EMIT} state_t;

  state_t          state_r;
  logic [VW-1:0]   clr_r;
  logic [9:0]      vtx_r [3];
  logic [1:0]      j_r;
  logic [FW-1:0]   face_r;
  logic            ovf_r;
  logic            in_range;
  logic            seen_rd;
  logic            ram_we;
  logic [VW-1:0]   ram_addr;
  logic            ram_wd;
  logic [9:0]      cur;
  logic [9:0]      nxt;
  logic [11:0]     base;

  assign cur      = vtx_r[j_r];
  assign nxt      = (j_r == 2'd2) ? vtx_r[0] : vtx_r[j_r + 2'd1];
  assign in_range = 32'(cur) < 32'(MAX_VERTICES);
  assign base     = 12'(face_r * 3);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = VW'(cur);
    ram_wd   = 1'b1;
    if (state_r == S_CLEAR) begin
      ram_we   = 1'b1;
      ram_addr = clr_r;
      ram_wd   = 1'b0;
    end else if (state_r == S_EMIT && job_ready && in_range && !seen_rd && !ovf_r) begin
      ram_we = 1'b1;
    end
  end

  hec_ram #(.WIDTH(1), .DEPTH(2 ** VW)) u_seen (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wd),
    .rdata(seen_rd)
  );

  assign busy      = state_r != S_IDLE;
  assign job_valid = state_r == S_EMIT;

  always_comb begin
    job          = '0;
    job.overflow = ovf_r;
    if (!ovf_r) begin
      job.cur    = cur;
      job.nxt    = nxt;
      job.he     = base + 12'(j_r);
      job.face   = 10'(face_r);
      job.corner = j_r;
      job.first  = in_range && !seen_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      face_r  <= '0;
      j_r     <= '0;
      ovf_r   <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_VERTICES - 1 || &clr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            vtx_r[0] <= in_vertex_a;
            vtx_r[1] <= in_vertex_b;
            vtx_r[2] <= in_vertex_c;
            j_r      <= '0;
            ovf_r    <= 32'(face_r) >= 32'(MAX_FACES);
            state_r  <= S_RD;
          end
        end
        S_RD:   state_r <= S_WAIT;
        S_WAIT: state_r <= S_EMIT;
        S_EMIT: begin
          if (job_ready) begin
            if (ovf_r) begin
              state_r <= S_IDLE;
            end else if (j_r == 2'd2) begin
              face_r  <= face_r + 1'b1;
              state_r <= S_IDLE;
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_face_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(face_r) <= 32'(MAX_FACES)) else $error("face count beyond capacity");
  a_job_corner: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> j_r != 2'd3) else $error("bad corner");
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> busy) else $error("idle during clear");
endmodule
`default_nettype wire

@@ rtl/hec_queue.sv @@
// Short queue of jobs between front and back.
// Depends on hec_pkg.
`default_nettype none
module hec_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  hec_pkg::job_t      wr_job,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  output hec_pkg::job_t      rd_job,
  output logic               rd_valid,
  input  wire logic          rd_ready
);
  hec_pkg::job_t q_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          wr_en;
  logic          rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = q_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= wr_job;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count overflow");
endmodule
`default_nettype wire

@@ rtl/hec_back.sv @@
// Back end: hash lookup and insert into the edge table, result words.
// Depends on hec_pkg and hec_ram (edge table with clearing sweep).
`default_nettype none
module hec_back #(
  parameter int TABLE_DEPTH = 4096,
  parameter int MAX_PROBES  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  hec_pkg::job_t      job,
  input  wire logic          job_valid,
  output logic               job_ready,
  output logic               out_strobe,
  output logic [11:0]        out_he_index,
  output logic [9:0]         out_origin_vertex,
  output logic [9:0]         out_face_index,
  output logic [11:0]        out_next_halfedge,
  output logic [11:0]        out_prev_halfedge,
  output logic signed [12:0] out_twin_halfedge,
  output logic [11:0]        out_edge_index,
  output logic               out_edge_created,
  output logic               out_vertex_first,
  output logic [1:0]         out_status,
  output logic               out_last_of_face
);
  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(MAX_PROBES + 1);
  // valid, ku, kv, edge, he
  localparam int EW = 1 + 10 + 10 + 12 + 12;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_FRD, S_FWAIT, S_FCHK, S_IRD, S_IWAIT, S_ICHK, S_OUT
  } state_t;

  state_t          state_r;
  hec_pkg::job_t   job_r;
  logic [31:0]     mu_r;
  logic [31:0]     mv_r;
  logic [TW-1:0]   slot_r;
  logic [PW-1:0]   probe_r;
  logic [TW-1:0]   clr_r;
  logic [11:0]     edge_cnt_r;
  logic            ram_we;
  logic [TW-1:0]   ram_addr;
  logic [EW-1:0]   ram_wd;
  logic [EW-1:0]   rd;
  logic            rd_v;
  logic [9:0]      rd_ku;
  logic [9:0]      rd_kv;
  logic [11:0]     rd_edge;
  logic [11:0]     rd_he;
  logic [11:0]     base;
  logic [31:0]     hsum;

  assign {rd_v, rd_ku, rd_kv, rd_edge, rd_he} = rd;
  assign base = job_r.he - 12'(job_r.corner);
  assign hsum = mu_r + mv_r;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = slot_r;
    ram_wd   = {1'b1, job_r.cur, job_r.nxt, edge_cnt_r, job_r.he};
    if (state_r == S_CLEAR) begin
      ram_we   = 1'b1;
      ram_addr = clr_r;
      ram_wd   = '0;
    end else if (state_r == S_ICHK && !rd_v) begin
      ram_we = 1'b1;
    end
  end

  hec_ram #(.WIDTH(EW), .DEPTH(2 ** TW)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wd),
    .rdata(rd)
  );

  assign job_ready = state_r == S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      edge_cnt_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            // lookup uses reversed key (nxt, cur)
            mu_r  <= 32'(job.nxt) * hec_pkg::HASH_U;
            mv_r  <= 32'(job.cur) * hec_pkg::HASH_V;
            if (job.overflow) begin
              out_he_index       <= '0;
              out_origin_vertex  <= '0;
              out_face_index     <= '0;
              out_next_halfedge  <= '0;
              out_prev_halfedge  <= '0;
              out_twin_halfedge  <= '0;
              out_edge_index     <= '0;
              out_edge_created   <= 1'b0;
              out_vertex_first   <= 1'b0;
              out_status         <= hec_pkg::ST_FACE_FULL;
              out_last_of_face   <= 1'b1;
              out_strobe         <= 1'b1;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          slot_r  <= TW'(hsum);
          probe_r <= '0;
          state_r <= S_FRD;
        end
        S_FRD:   state_r <= S_FWAIT;
        S_FWAIT: state_r <= S_FCHK;
        S_FCHK: begin
          if (rd_v && rd_ku == job_r.nxt && rd_kv == job_r.cur) begin
            out_twin_halfedge <= $signed({1'b0, rd_he});
            out_edge_index    <= rd_edge;
            out_edge_created  <= 1'b0;
            out_status        <= hec_pkg::ST_OK;
            state_r           <= S_OUT;
          end else if (!rd_v || 32'(probe_r) == MAX_PROBES - 1) begin
            mu_r    <= 32'(job_r.cur) * hec_pkg::HASH_U;
            mv_r    <= 32'(job_r.nxt) * hec_pkg::HASH_V;
            state_r <= S_IWAIT;
            probe_r <= '0;
          end else begin
            slot_r  <= slot_r + 1'b1;
            probe_r <= probe_r + 1'b1;
            state_r <= S_FRD;
          end
        end
        S_IWAIT: begin
          // hash of forward key settles into slot
          slot_r  <= TW'(hsum);
          state_r <= S_IRD;
        end
        S_IRD: state_r <= S_ICHK;
        S_ICHK: begin
          if (!rd_v || (rd_ku == job_r.cur && rd_kv == job_r.nxt)) begin
            out_twin_halfedge <= -13'sd1;
            out_edge_index    <= edge_cnt_r;
            out_edge_created  <= 1'b1;
            out_status        <= hec_pkg::ST_OK;
            edge_cnt_r        <= edge_cnt_r + 1'b1;
            state_r           <= S_OUT;
          end else if (32'(probe_r) == MAX_PROBES - 1) begin
            out_twin_halfedge <= -13'sd1;
            out_edge_index    <= edge_cnt_r;
            out_edge_created  <= 1'b1;
            out_status        <= hec_pkg::ST_EDGE_FULL;
            edge_cnt_r        <= edge_cnt_r + 1'b1;
            state_r           <= S_OUT;
          end else begin
            slot_r  <= slot_r + 1'b1;
            probe_r <= probe_r + 1'b1;
            state_r <= S_IRD;
          end
        end
        S_OUT: begin
          out_he_index       <= job_r.he;
          out_origin_vertex  <= job_r.cur;
          out_face_index     <= job_r.face;
          out_next_halfedge  <= base + ((job_r.corner == 2'd2) ? 12'd0 : 12'(job_r.corner) + 12'd1);
          out_prev_halfedge  <= base + ((job_r.corner == 2'd0) ? 12'd2 : 12'(job_r.corner) - 12'd1);
          out_vertex_first   <= job_r.first;
          out_last_of_face   <= job_r.corner == 2'd2;
          out_strobe         <= 1'b1;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    32'(probe_r) < MAX_PROBES || state_r == S_IDLE || state_r == S_CLEAR || state_r == S_HASH)
    else $error("probe count beyond limit");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_OUT || $past(state_r) == S_IDLE)
    else $error("stray result strobe");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !job_ready) else $error("job taken during clear");
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for half_edge_connectivity_builder: directed, random and
// edge-table-full triangles checked against a built-in predictor.
// Depends on hec_pkg and the RTL of the half-edge connectivity builder.
module testbench;
  localparam int NUM_VERTS  = 1024;
  localparam int NUM_FACES  = 1024;
  localparam int SLOTS      = 4096;
  localparam int PROBES     = 8;
  localparam int LIMIT      = 2000000;

  typedef struct {
    logic [11:0]        he;
    logic [9:0]         origin;
    logic [9:0]         face;
    logic [11:0]        nxt;
    logic [11:0]        prv;
    logic signed [12:0] twin;
    logic [11:0]        edge_idx;
    logic               created;
    logic               first;
    hec_pkg::status_t   status;
    logic               last;
  } halfedge_word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic [9:0] in_vertex_a = 0, in_vertex_b = 0, in_vertex_c = 0;
  logic busy, out_strobe;
  logic [11:0] out_he_index, out_next_halfedge, out_prev_halfedge, out_edge_index;
  logic [9:0] out_origin_vertex, out_face_index;
  logic signed [12:0] out_twin_halfedge;
  logic out_edge_created, out_vertex_first, out_last_of_face;
  logic [1:0] out_status;

  // predictor state
  logic        slot_valid [SLOTS];
  logic [9:0]  slot_u [SLOTS];
  logic [9:0]  slot_v [SLOTS];
  logic [11:0] slot_edge [SLOTS];
  logic [11:0] slot_he [SLOTS];
  logic        vert_seen [NUM_VERTS];
  int unsigned faces_built, edges_built;

  halfedge_word_t pending_words[$];
  int errors = 0;
  int unsigned cycles = 0;

  half_edge_connectivity_builder DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [11:0] slot_hash(logic [9:0] u, logic [9:0] v);
    logic [31:0] m;
    m = 32'(u) * hec_pkg::HASH_U + 32'(v) * hec_pkg::HASH_V;
    return m[11:0];
  endfunction

  function automatic int find_slot(logic [9:0] u, logic [9:0] v);
    int s;
    for (int p = 0; p < PROBES; p++) begin
      s = (slot_hash(u, v) + p) % SLOTS;
      if (!slot_valid[s]) return -1;
      if (slot_u[s] == u && slot_v[s] == v) return s;
    end
    return -1;
  endfunction

  function automatic bit insert_key(logic [9:0] u, logic [9:0] v, logic [11:0] e,
                                    logic [11:0] h);
    int s;
    for (int p = 0; p < PROBES; p++) begin
      s = (slot_hash(u, v) + p) % SLOTS;
      if (!slot_valid[s]) begin
        slot_valid[s] = 1;
        slot_u[s] = u;
        slot_v[s] = v;
        slot_edge[s] = e;
        slot_he[s] = h;
        return 0;
      end
      if (slot_u[s] == u && slot_v[s] == v) return 0;
    end
    return 1;
  endfunction

  task automatic build_triangle(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    logic [9:0] vtx [3];
    halfedge_word_t w;
    int s;
    int unsigned base;
    vtx[0] = a; vtx[1] = b; vtx[2] = c;
    if (faces_built >= NUM_FACES) begin
      w = '{default: 0, status: hec_pkg::ST_FACE_FULL};
      w.last = 1;
      pending_words.insert(pending_words.size(), w);
      return;
    end
    base = faces_built * 3;
    for (int j = 0; j < 3; j++) begin
      w.he = 12'(base + j);
      w.origin = vtx[j];
      w.face = 10'(faces_built);
      w.nxt = 12'(base + (j + 1) % 3);
      w.prv = 12'(base + (j + 2) % 3);
      w.first = !vert_seen[vtx[j]];
      vert_seen[vtx[j]] = 1;
      w.status = hec_pkg::ST_OK;
      s = find_slot(vtx[(j + 1) % 3], vtx[j]);
      if (s >= 0) begin
        w.twin = $signed({1'b0, slot_he[s]});
        w.edge_idx = slot_edge[s];
        w.created = 0;
      end else begin
        w.twin = -13'sd1;
        w.edge_idx = 12'(edges_built);
        edges_built++;
        w.created = 1;
        if (insert_key(vtx[j], vtx[(j + 1) % 3], w.edge_idx, w.he))
          w.status = hec_pkg::ST_EDGE_FULL;
      end
      w.last = (j == 2);
      pending_words.insert(pending_words.size(), w);
    end
    faces_built++;
  endtask

  task automatic send_triangle(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    @(negedge clk);
    start = 1;
    in_vertex_a = a;
    in_vertex_b = b;
    in_vertex_c = c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    build_triangle(a, b, c);
  endtask

  task automatic idle_gap(int n);
    if (n == 0) return;
    @(negedge clk);
    start = 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle_gap(1);
    wait (pending_words.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic compare_field(string name, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    halfedge_word_t w;
    if (rst_n && out_strobe) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got he %0d", $time,
                 out_he_index);
        errors++;
      end else begin
        w = pending_words.pop_front();
        compare_field("he_index", w.he, out_he_index);
        compare_field("origin_vertex", w.origin, out_origin_vertex);
        compare_field("face_index", w.face, out_face_index);
        compare_field("next_halfedge", w.nxt, out_next_halfedge);
        compare_field("prev_halfedge", w.prv, out_prev_halfedge);
        compare_field("twin_halfedge", w.twin, out_twin_halfedge);
        compare_field("edge_index", w.edge_idx, out_edge_index);
        compare_field("edge_created", w.created, out_edge_created);
        compare_field("vertex_first", w.first, out_vertex_first);
        compare_field("status", w.status, out_status);
        compare_field("last_of_face", w.last, out_last_of_face);
      end
    end
  end

  task automatic test_directed();
    send_triangle(0, 1, 2);
    send_triangle(1, 0, 1023);
    send_triangle(0, 1, 2);
    idle_gap(3);
    send_triangle(1023, 1022, 512);
    send_triangle(5, 5, 5);
    send_triangle(7, 7, 8);
    send_triangle(2, 1, 1023);
    idle_gap(1);
    send_triangle(341, 682, 1023);
    send_triangle(682, 341, 0);
    send_triangle(1023, 1023, 0);
    drain();
  endtask

  task automatic test_edge_table_full();
    int inv, target, found, u;
    for (inv = 1; inv < SLOTS; inv += 2)
      if ((3639 * inv) % SLOTS == 1) break;
    target = $urandom_range(0, SLOTS - 1);
    found = 0;
    for (int v = 0; v < NUM_VERTS && found < 11; v++) begin
      u = ((target - v * 2481) % SLOTS + SLOTS) % SLOTS;
      u = (u * inv) % SLOTS;
      if (u < NUM_VERTS && u != v && slot_hash(10'(u), 10'(v)) == 12'(target)) begin
        send_triangle(10'(u), 10'(v), 10'($urandom_range(0, 1023)));
        found++;
      end
    end
    drain();
  endtask

  task automatic test_random(int count);
    logic [9:0] pa, pb, pc;
    int burst;
    pa = 10'($urandom); pb = 10'($urandom); pc = 10'($urandom);
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        idle_gap($urandom_range(0, 12));
        burst = $urandom_range(1, 10);
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          pa = pb; pb = pa == pc ? 10'($urandom) : pc; pc = 10'($urandom_range(0, 63));
          {pa, pb} = {pb, pa};
        end
        4, 5, 6: begin
          pa = 10'($urandom_range(0, 31));
          pb = 10'($urandom_range(0, 31));
          pc = 10'($urandom_range(0, 31));
        end
        default: begin
          pa = 10'($urandom); pb = 10'($urandom); pc = 10'($urandom);
        end
      endcase
      send_triangle(pa, pb, pc);
      if (i == count / 2) drain();
    end
    drain();
  endtask

  initial begin
    foreach (slot_valid[i]) slot_valid[i] = 0;
    foreach (vert_seen[i]) vert_seen[i] = 0;
    faces_built = 0;
    edges_built = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_edge_table_full();
    test_random(310);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/hec_pkg.sv
rtl/hec_ram.sv
rtl/hec_front.sv
rtl/hec_queue.sv
rtl/hec_back.sv
rtl/half_edge_connectivity_builder.sv
dv/testbench.sv
